/* sv/mbv_pkg.sv */
// Shared constants and helpers for the mapping blob validator.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package mbv_pkg;

  localparam int unsigned HDR_LEN = 12;

  localparam logic [7:0]  MAGIC_0  = 8'h50;  // 'P'
  localparam logic [7:0]  MAGIC_1  = 8'h42;  // 'B'
  localparam logic [7:0]  VER_MIN  = 8'd3;
  localparam logic [7:0]  VER_MID  = 8'd4;
  localparam logic [7:0]  VER_MAX  = 8'd5;
  localparam logic [7:0]  BLOB_TYPE = 8'd1;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_HDR_SHORT   = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC   = 4'd2;
  localparam logic [3:0] ST_BAD_VERTYPE = 4'd3;
  localparam logic [3:0] ST_SIZE        = 4'd4;
  localparam logic [3:0] ST_CRC         = 4'd5;
  localparam logic [3:0] ST_CNT_SHORT   = 4'd6;
  localparam logic [3:0] ST_LENGTH      = 4'd7;
  localparam logic [3:0] ST_ENTRY_SHORT = 4'd8;
  localparam logic [3:0] ST_OVERFLOW    = 4'd9;

  // header fault codes
  localparam logic [1:0] HF_NONE    = 2'd0;
  localparam logic [1:0] HF_MAGIC   = 2'd1;
  localparam logic [1:0] HF_VERTYPE = 2'd2;

  // reflected CRC-32 table entry; maps to a 256-entry constant table
  function automatic logic [31:0] crc_tab(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // trailing bytes of a binding entry by version
  function automatic logic [3:0] extra_len(input logic [7:0] ver);
    if (ver >= VER_MAX) return 4'd9;
    if (ver >= VER_MID) return 4'd2;
    return 4'd0;
  endfunction

endpackage

`default_nettype wire

/* sv/mbv_in_if.sv */
// Input channel: blob bytes with last-byte flag, valid/ready handshake.
// No dependencies.
`default_nettype none

interface mbv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* sv/mbv_out_if.sv */
// Result channel: status and safe-entry count, valid/ready handshake.
// No dependencies.
`default_nettype none

interface mbv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] safe_count;

  modport source (output valid, output status, output safe_count, input ready);
  modport sink   (input valid, input status, input safe_count, output ready);
endinterface

`default_nettype wire

/* sv/mapping_blob_validator_top.sv */
// Mapping blob validator: header check, payload CRC-32 and structure walk.
// Depends on mbv_pkg, mbv_in_if, mbv_out_if.
//
//   channel  | dir | payload                         | item
//   ---------+-----+---------------------------------+---------------------------
//   blob     | in  | data_byte[7:0], last_byte       | one blob byte
//   result   | out | status[3:0], safe_count[15:0]   | one status per blob
//
// One byte per cycle while blob.ready is high: the CRC table lookup and walk
// step update the parse state in the cycle the byte is accepted. A byte flagged
// last loads the result register at the edge that accepts it, so the result is
// valid from the next cycle, and returns the parse state to reset.
// rst is synchronous and clears parse state and the result valid.
// blob.ready drops only while a result is held and result.ready is low.
`default_nettype none

module mapping_blob_validator_top (
  input  wire logic clk,
  input  wire logic rst,
  mbv_in_if.sink    blob,
  mbv_out_if.source result
);
  import mbv_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_CNT_LO, PH_CNT_HI, PH_SAFE, PH_BC_LO, PH_BC_HI,
    PH_COMP_LEN, PH_COMP, PH_FN_LEN, PH_FN, PH_DRV_LEN, PH_DRV,
    PH_EXTRA, PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [7:0]  header_version, header_version_next;
  logic [31:0] payload_length, payload_length_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic [7:0]  field_bytes_left, field_bytes_left_next;
  logic [15:0] entry_count, entry_count_next;
  logic [15:0] bindings_left, bindings_left_next;
  logic [1:0]  header_fault, header_fault_next;
  logic [3:0]  structure_fault, structure_fault_next;

  logic        res_valid;
  logic [3:0]  res_status;
  logic [15:0] res_safe;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] p;
  logic [32:0] consumed;
  logic [33:0] need_len;
  logic [17:0] entry_bytes;
  logic [18:0] safe_need;
  logic [15:0] ec_full;
  logic [4:0]  lane;
  logic [3:0]  status_next;
  logic [3:0]  extra;

  assign accept      = blob.valid & blob.ready;
  assign blob.ready  = ~res_valid | result.ready;
  assign b           = blob.data_byte;
  assign p           = byte_position - 32'(HDR_LEN);
  assign consumed    = {1'b0, p} + 33'd1;
  assign lane        = {byte_position[1:0], 3'b000};
  assign ec_full     = {b, entry_count[7:0]};
  assign entry_bytes = {1'b0, ec_full, 1'b0} + {2'b00, ec_full};
  assign safe_need   = {1'b0, entry_bytes} + 19'd4;
  assign extra       = extra_len(header_version);

  always_comb begin
    phase_next            = phase;
    header_version_next   = header_version;
    payload_length_next   = payload_length;
    expected_crc_next     = expected_crc;
    running_crc_next      = running_crc;
    field_bytes_left_next = field_bytes_left;
    entry_count_next      = entry_count;
    bindings_left_next    = bindings_left;
    header_fault_next     = header_fault;
    structure_fault_next  = structure_fault;
    need_len              = '0;

    if (byte_position < 32'(HDR_LEN)) begin
      unique case (byte_position[3:0])
        4'd0: if (b != MAGIC_0 && header_fault == HF_NONE) header_fault_next = HF_MAGIC;
        4'd1: if (b != MAGIC_1 && header_fault == HF_NONE) header_fault_next = HF_MAGIC;
        4'd2: header_version_next = b;
        4'd3: begin
          if (!(header_version == VER_MIN || header_version == VER_MID ||
                header_version == VER_MAX) || b != BLOB_TYPE) begin
            if (header_fault == HF_NONE) header_fault_next = HF_VERTYPE;
          end
        end
        4'd4, 4'd5, 4'd6, 4'd7: payload_length_next[lane +: 8] = b;
        default: expected_crc_next[lane +: 8] = b;
      endcase
      if (byte_position[3:0] == 4'(HDR_LEN - 1)) phase_next = PH_CNT_LO;
    end else if (p < payload_length) begin
      running_crc_next = crc_tab(running_crc[7:0] ^ b) ^ (running_crc >> 8);
      if (structure_fault == ST_OK) begin
        unique case (phase)
          PH_CNT_LO: begin
            entry_count_next = {8'd0, b};
            phase_next       = PH_CNT_HI;
          end
          PH_CNT_HI: begin
            entry_count_next = ec_full;
            if (payload_length < {13'd0, safe_need}) begin
              structure_fault_next = ST_LENGTH;
            end else if (ec_full != 16'd0) begin
              bindings_left_next    = ec_full;
              field_bytes_left_next = 8'd3;
              phase_next            = PH_SAFE;
            end else begin
              phase_next = PH_BC_LO;
            end
          end
          PH_SAFE: begin
            field_bytes_left_next = field_bytes_left - 8'd1;
            if (field_bytes_left == 8'd1) begin
              bindings_left_next = bindings_left - 16'd1;
              if (bindings_left != 16'd1) field_bytes_left_next = 8'd3;
              else phase_next = PH_BC_LO;
            end
          end
          PH_BC_LO: begin
            field_bytes_left_next = b;
            phase_next            = PH_BC_HI;
          end
          PH_BC_HI: begin
            bindings_left_next = {b, field_bytes_left};
            phase_next = ({b, field_bytes_left} != 16'd0) ? PH_COMP_LEN : PH_DONE;
          end
          PH_COMP_LEN, PH_FN_LEN: begin
            need_len = {1'b0, consumed} + {26'd0, b} + 34'd1;
            if (need_len > {2'b00, payload_length}) begin
              structure_fault_next = ST_OVERFLOW;
            end else begin
              field_bytes_left_next = b;
              if (phase == PH_COMP_LEN) phase_next = (b != 8'd0) ? PH_COMP : PH_FN_LEN;
              else phase_next = (b != 8'd0) ? PH_FN : PH_DRV_LEN;
            end
          end
          PH_COMP, PH_FN: begin
            field_bytes_left_next = field_bytes_left - 8'd1;
            if (field_bytes_left == 8'd1)
              phase_next = (phase == PH_COMP) ? PH_FN_LEN : PH_DRV_LEN;
          end
          PH_DRV_LEN: begin
            need_len = {1'b0, consumed} + {26'd0, b} + {30'd0, extra};
            if (need_len > {2'b00, payload_length}) begin
              structure_fault_next = ST_OVERFLOW;
            end else begin
              field_bytes_left_next = b;
              if (b != 8'd0) begin
                phase_next = PH_DRV;
              end else if (extra != 4'd0) begin
                field_bytes_left_next = {4'd0, extra};
                phase_next            = PH_EXTRA;
              end else begin
                bindings_left_next = bindings_left - 16'd1;
                phase_next = (bindings_left != 16'd1) ? PH_COMP_LEN : PH_DONE;
              end
            end
          end
          PH_DRV: begin
            field_bytes_left_next = field_bytes_left - 8'd1;
            if (field_bytes_left == 8'd1) begin
              if (extra != 4'd0) begin
                field_bytes_left_next = {4'd0, extra};
                phase_next            = PH_EXTRA;
              end else begin
                bindings_left_next = bindings_left - 16'd1;
                phase_next = (bindings_left != 16'd1) ? PH_COMP_LEN : PH_DONE;
              end
            end
          end
          PH_EXTRA: begin
            field_bytes_left_next = field_bytes_left - 8'd1;
            if (field_bytes_left == 8'd1) begin
              bindings_left_next = bindings_left - 16'd1;
              phase_next = (bindings_left != 16'd1) ? PH_COMP_LEN : PH_DONE;
            end
          end
          default: structure_fault_next = ST_LENGTH;  // payload past the structure
        endcase
      end
    end

    byte_position_next = (byte_position == '1) ? byte_position : byte_position + 32'd1;

    // status ranking: header, size, crc, structure
    if (byte_position_next < 32'(HDR_LEN))
      status_next = ST_HDR_SHORT;
    else if (header_fault_next == HF_MAGIC)
      status_next = ST_BAD_MAGIC;
    else if (header_fault_next != HF_NONE)
      status_next = ST_BAD_VERTYPE;
    else if ({1'b0, byte_position_next} != {1'b0, payload_length_next} + 33'(HDR_LEN))
      status_next = ST_SIZE;
    else if (~running_crc_next != expected_crc_next)
      status_next = ST_CRC;
    else if (structure_fault_next != ST_OK)
      status_next = structure_fault_next;
    else if (phase_next == PH_CNT_LO || phase_next == PH_CNT_HI)
      status_next = ST_CNT_SHORT;
    else if (phase_next != PH_DONE)
      status_next = ST_ENTRY_SHORT;
    else
      status_next = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && blob.last_byte)) begin
      phase            <= PH_HEADER;
      byte_position    <= '0;
      header_version   <= '0;
      payload_length   <= '0;
      expected_crc     <= '0;
      running_crc      <= '1;
      field_bytes_left <= '0;
      entry_count      <= '0;
      bindings_left    <= '0;
      header_fault     <= HF_NONE;
      structure_fault  <= ST_OK;
    end else if (accept) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      header_version   <= header_version_next;
      payload_length   <= payload_length_next;
      expected_crc     <= expected_crc_next;
      running_crc      <= running_crc_next;
      field_bytes_left <= field_bytes_left_next;
      entry_count      <= entry_count_next;
      bindings_left    <= bindings_left_next;
      header_fault     <= header_fault_next;
      structure_fault  <= structure_fault_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && blob.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (accept && blob.last_byte) begin
      res_status <= status_next;
      res_safe   <= (status_next == ST_OK) ? entry_count_next : 16'd0;
    end
  end

  assign result.valid      = res_valid;
  assign result.status     = res_status;
  assign result.safe_count = res_safe;

endmodule

`default_nettype wire

/* sv/mbv_checker.sv */
// Port-level checks for mapping_blob_validator_top, attached by bind.
// Depends on mbv_pkg.
`default_nettype none

module mbv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_status,
  input wire logic [15:0] out_safe_count
);
  import mbv_pkg::*;

  // held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_safe_count))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_OVERFLOW)
    else $error("status code out of range");

  a_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_safe_count == 16'd0)
    else $error("safe count set on failed blob");

  // last byte gives a result in the next cycle
  a_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result after last byte");

  // no result appears without a last byte
  a_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready && in_last) |=> !out_valid)
    else $error("result without last byte");

endmodule

bind mapping_blob_validator_top mbv_checker u_mbv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (blob.valid),
  .in_ready       (blob.ready),
  .in_last        (blob.last_byte),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .out_status     (result.status),
  .out_safe_count (result.safe_count)
);

`default_nettype wire
